// File: rtl/binary_to_decimal_ascii_macros.svh
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// property holds in the same cycle
`define B2DA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da assertion failed");
// property holds in the following cycle
`define B2DA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da assertion failed");
`else
`define B2DA_ASSERT(label, ante, cons)
`define B2DA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/b2da_pkg.sv
// ---------------------------------------------------------------------------
// b2da_pkg
// shared widths, constants and controller/datapath structs
// ---------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W    = 64;
  localparam int PAD_W      = 5;
  localparam int CHAR_W     = 6;
  localparam int MAX_DIGITS = 20;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int POS_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             step;
    logic [POS_W-1:0] pos;
  } b2da_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } b2da_sts_t;

endpackage

`default_nettype wire

// File: rtl/b2da_in_if.sv
// ---------------------------------------------------------------------------
// b2da_in_if
// input channel: value and minimum field width
// ---------------------------------------------------------------------------
`default_nettype none

interface b2da_in_if;
  logic                          valid;
  logic                          ready;
  logic [b2da_pkg::VALUE_W-1:0]  value;
  logic [b2da_pkg::PAD_W-1:0]    pad_width;

  modport source (output valid, output value, output pad_width, input ready);
  modport sink (input valid, input value, input pad_width, output ready);
endinterface

`default_nettype wire

// File: rtl/b2da_out_if.sv
// ---------------------------------------------------------------------------
// b2da_out_if
// output channel: one ascii digit per item with end flag
// ---------------------------------------------------------------------------
`default_nettype none

interface b2da_out_if;
  logic                         valid;
  logic                         ready;
  logic [b2da_pkg::CHAR_W-1:0]  digit_char;
  logic                         last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/b2da_ctrl.sv
// ---------------------------------------------------------------------------
// b2da_ctrl
// sequencer: load, 64 shift-add-3 steps, then a scan over digit positions
// ---------------------------------------------------------------------------
`default_nettype none

module b2da_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire b2da_pkg::b2da_sts_t sts_i,
  output b2da_pkg::b2da_cmd_t      cmd_o
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.pos  = cnt_q[POS_W-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (cnt_q == CNT_W'(VALUE_W - 1)) begin
          cnt_d   = CNT_W'(MAX_DIGITS - 1);
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        // hold the scan while the output register is still occupied
        if (!sts_i.out_busy) begin
          cmd_o.step = 1'b1;
          if (cnt_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b2da_dp.sv
// ---------------------------------------------------------------------------
// b2da_dp
// double-dabble bcd register, leading-zero suppression and output register
// ---------------------------------------------------------------------------
`default_nettype none

module b2da_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire b2da_pkg::b2da_cmd_t           cmd_i,
  input  wire logic [b2da_pkg::VALUE_W-1:0]  in_value_i,
  input  wire logic [b2da_pkg::PAD_W-1:0]    in_pad_width_i,
  input  wire logic                          out_ready_i,
  output b2da_pkg::b2da_sts_t                sts_o,
  output logic                               out_valid_o,
  output logic [b2da_pkg::CHAR_W-1:0]        out_digit_char_o,
  output logic                               out_last_o
);
  import b2da_pkg::*;

  logic [VALUE_W-1:0] value_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   bcd_adj;
  logic [PAD_W-1:0]   pad_q;
  logic               started_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic [3:0]         digit;
  logic               emit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  assign digit = bcd_q[cmd_i.pos*4 +: 4];
  // leading zeros are dropped unless inside the pad field or the units digit
  assign emit  = started_q || (digit != 4'd0) || (cmd_i.pos < pad_q) ||
                 (cmd_i.pos == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_value_i;
      bcd_q   <= '0;
      pad_q   <= in_pad_width_i;
    end else if (cmd_i.shift) begin
      value_q <= {value_q[VALUE_W-2:0], 1'b0};
      bcd_q   <= {bcd_adj[BCD_W-2:0], value_q[VALUE_W-1]};
    end
    if (cmd_i.step && emit) begin
      char_q <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, digit};
      last_q <= (cmd_i.pos == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        started_q <= 1'b0;
      end else if (cmd_i.step && emit) begin
        started_q <= 1'b1;
      end
      if (cmd_i.step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_digit_char_o = char_q;
  assign out_last_o       = last_q;

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii: 64-bit unsigned to zero-padded decimal ascii
// conversion: load, shift-add-3 over the 64 input bits, then a 20-position scan
// output: one item per cycle while not stalled; a new input waits until the scan is done
// reset: asynchronous active low, clears controller and output valid, not payload
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

module binary_to_decimal_ascii (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b2da_in_if.sink   in_i,
  b2da_out_if.source out_o
);
  import b2da_pkg::*;

  // command and status bundles between sequencer and datapath
  b2da_cmd_t cmd;
  b2da_sts_t sts;

  // sequencer: idle, conversion shift loop, digit scan from the top position down
  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: bcd accumulation, zero suppression, registered output item
  b2da_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .in_value_i       (in_i.value),
    .in_pad_width_i   (in_i.pad_width),
    .out_ready_i      (out_o.ready),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_digit_char_o (out_o.digit_char),
    .out_last_o       (out_o.last)
  );

  // a new item is only taken while no conversion or scan is running
  `B2DA_ASSERT(a_ready_idle, in_i.ready, !cmd.shift && !cmd.step)
  // the shift loop always starts right after an item is taken
  `B2DA_ASSERT_NEXT(a_load_shift, cmd.load, cmd.shift)
  // the scan never overwrites an item still waiting at the output
  `B2DA_ASSERT(a_no_overwrite, cmd.step && out_o.valid, out_o.ready)

endmodule

`default_nettype wire
